// ===== rtl/vfcao_pkg.sv =====
// Package for the voxel face cull and ambient occlusion block.
// Holds word types, register codes and the face and vertex tables.
// Has no dependencies; every rtl file uses it by scoped names.
package vfcao_pkg;

    localparam int CHUNK_HEIGHT = 256;
    localparam int NUM_FACES    = 6;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 9;
    localparam int Q_DEPTH      = 2;
    localparam int Q_PTR_W      = $clog2(Q_DEPTH);
    localparam int OUT_DEPTH    = 4;
    localparam int OUT_PTR_W    = $clog2(OUT_DEPTH);

    typedef logic [4:0] nb_idx_t;

    typedef struct packed {
        logic [7:0]  block_type;
        logic [26:0] neighbours;
        logic [3:0]  pos_x;
        logic [7:0]  pos_y;
        logic [3:0]  pos_z;
    } item_t;

    typedef struct packed {
        logic [2:0] face;
        logic [7:0] tex_index;
        logic [3:0] out_x;
        logic [7:0] out_y;
        logic [3:0] out_z;
        logic [8:0] shade_a;
        logic [8:0] shade_b;
        logic [8:0] shade_c;
        logic [8:0] shade_d;
        logic       flip_diagonal;
        logic       last_face;
    } result_t;

    typedef struct packed {
        logic [NUM_FACES-1:0] mask;
        item_t                item;
    } cls_t;

    typedef struct packed {
        logic [6:0] occlusion_step;
        logic [8:0] top_light;
        logic [8:0] light_side_x;
        logic [8:0] light_side_z;
        logic [8:0] light_bottom;
    } cfg_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OCC_STEP     = 3'd0,
        REG_TOP_LIGHT    = 3'd1,
        REG_LIGHT_SIDE_X = 3'd2,
        REG_LIGHT_SIDE_Z = 3'd3,
        REG_LIGHT_BOTTOM = 3'd4
    } cfg_idx_t;

    typedef enum logic [2:0] {
        FACE_LEFT   = 3'd0,
        FACE_RIGHT  = 3'd1,
        FACE_FRONT  = 3'd2,
        FACE_BACK   = 3'd3,
        FACE_TOP    = 3'd4,
        FACE_BOTTOM = 3'd5
    } face_t;

    typedef enum logic [1:0] {
        LIGHT_UP,
        LIGHT_SIDE_X,
        LIGHT_SIDE_Z,
        LIGHT_BOTTOM
    } light_sel_t;

    localparam cfg_t CFG_RESET = '{
        occlusion_step: 7'd38,
        top_light:      9'd256,
        light_side_x:   9'd230,
        light_side_z:   9'd205,
        light_bottom:   9'd179
    };

    function automatic nb_idx_t nb(input int dx, input int dy, input int dz);
        return nb_idx_t'((dy + 1) * 9 + (dz + 1) * 3 + (dx + 1));
    endfunction

    localparam nb_idx_t FACE_NB [NUM_FACES] = '{
        nb(-1, 0, 0), nb(1, 0, 0), nb(0, 0, 1),
        nb(0, 0, -1), nb(0, 1, 0), nb(0, -1, 0)
    };

    localparam nb_idx_t FACE_VTX [NUM_FACES][4][3] = '{
        '{ '{nb(-1, 0, 1),  nb(-1, -1, 0), nb(-1, -1, 1)},
           '{nb(-1, -1, 0), nb(-1, 0, -1), nb(-1, -1, -1)},
           '{nb(-1, 0, -1), nb(-1, 1, 0),  nb(-1, 1, -1)},
           '{nb(-1, 1, 0),  nb(-1, 0, 1),  nb(-1, 1, 1)} },
        '{ '{nb(1, 0, 1),   nb(1, -1, 0),  nb(1, -1, 1)},
           '{nb(1, -1, 0),  nb(1, 0, -1),  nb(1, -1, -1)},
           '{nb(1, 0, -1),  nb(1, 1, 0),   nb(1, 1, -1)},
           '{nb(1, 1, 0),   nb(1, 0, 1),   nb(1, 1, 1)} },
        '{ '{nb(-1, 0, 1),  nb(0, -1, 1),  nb(-1, -1, 1)},
           '{nb(0, -1, 1),  nb(1, 0, 1),   nb(1, -1, 1)},
           '{nb(1, 0, 1),   nb(0, 1, 1),   nb(1, 1, 1)},
           '{nb(0, 1, 1),   nb(-1, 0, 1),  nb(-1, 1, 1)} },
        '{ '{nb(-1, 0, -1), nb(0, -1, -1), nb(-1, -1, -1)},
           '{nb(0, -1, -1), nb(1, 0, -1),  nb(1, -1, -1)},
           '{nb(1, 0, -1),  nb(0, 1, -1),  nb(1, 1, -1)},
           '{nb(0, 1, -1),  nb(-1, 0, -1), nb(-1, 1, -1)} },
        '{ '{nb(-1, 1, 0),  nb(0, 1, 1),   nb(-1, 1, 1)},
           '{nb(0, 1, 1),   nb(1, 1, 0),   nb(1, 1, 1)},
           '{nb(1, 1, 0),   nb(0, 1, -1),  nb(1, 1, -1)},
           '{nb(0, 1, -1),  nb(-1, 1, 0),  nb(-1, 1, -1)} },
        '{ '{nb(-1, -1, 0), nb(0, -1, 1),  nb(-1, -1, 1)},
           '{nb(0, -1, 1),  nb(1, -1, 0),  nb(1, -1, 1)},
           '{nb(1, -1, 0),  nb(0, -1, -1), nb(1, -1, -1)},
           '{nb(0, -1, -1), nb(-1, -1, 0), nb(-1, -1, -1)} }
    };

    localparam logic [1:0] FACE_ORDER [NUM_FACES][4] = '{
        '{2'd1, 2'd0, 2'd3, 2'd2},
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd1, 2'd0, 2'd3, 2'd2},
        '{2'd0, 2'd1, 2'd2, 2'd3},
        '{2'd3, 2'd2, 2'd1, 2'd0}
    };

    localparam logic FACE_FLIP_LESS [NUM_FACES] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

    localparam light_sel_t FACE_LIGHT [NUM_FACES] = '{
        LIGHT_SIDE_X, LIGHT_SIDE_X, LIGHT_SIDE_Z,
        LIGHT_SIDE_Z, LIGHT_UP, LIGHT_BOTTOM
    };

endpackage

// ===== rtl/voxel_face_cull_ambient_occlusion_top.sv =====
// Top level of the voxel face cull and ambient occlusion block.
// Holds the configuration registers and connects front, queue and back.
// Depends on vfcao_pkg, vfcao_front, vfcao_queue and vfcao_back.
//
// The input side is a queue write port: a word (block type, 27 neighbour
// bits and position) is taken when push is high and full is low. Each solid
// block yields one result word per open face, in the order left, right,
// front, back, top, bottom, with last_face set on the final one. Blocks of
// type none or air, and solid blocks with no open face, yield nothing.
// The result side is a queue read port: the oldest word is shown while
// empty is low and leaves when pop is high.
// A queued block has one to six open faces; the first passes through the
// face queue, the stage register and the result buffer. The walker issues
// one face per cycle while there is room for it, and a two-entry queue lets
// the input run ahead. When the receiver stalls, the four-entry result
// buffer fills, the walker holds and full then rises; nothing is lost.
// Configuration writes are taken at once (cfg_ready is always high) and
// should be made only while the block is idle. Reset empties all queues
// and loads the default step and light values.
module voxel_face_cull_ambient_occlusion_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  vfcao_pkg::item_t                   item,
    input  logic                               push,
    output logic                               full,
    output vfcao_pkg::result_t                 result,
    output logic                               empty,
    input  logic                               pop,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [vfcao_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vfcao_pkg::CFG_DATA_W-1:0]   cfg_data
);

    vfcao_pkg::cfg_t cfg_reg, cfg_next;
    logic            q_full;
    logic            q_push;
    vfcao_pkg::cls_t q_wr_word;
    logic            q_valid;
    vfcao_pkg::cls_t q_rd_word;
    logic            q_pop;

    always_comb
    begin
        cfg_ready = 1'b1;
        cfg_next  = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                vfcao_pkg::REG_OCC_STEP:     cfg_next.occlusion_step = cfg_data[6:0];
                vfcao_pkg::REG_TOP_LIGHT:    cfg_next.top_light      = cfg_data;
                vfcao_pkg::REG_LIGHT_SIDE_X: cfg_next.light_side_x   = cfg_data;
                vfcao_pkg::REG_LIGHT_SIDE_Z: cfg_next.light_side_z   = cfg_data;
                vfcao_pkg::REG_LIGHT_BOTTOM: cfg_next.light_bottom   = cfg_data;
                default:                     cfg_next                = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= vfcao_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    vfcao_front u_front (
        .item   (item),
        .push   (push),
        .q_full (q_full),
        .full   (full),
        .q_push (q_push),
        .q_word (q_wr_word)
    );

    vfcao_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_word),
        .full    (q_full),
        .valid   (q_valid),
        .rd_data (q_rd_word),
        .rd_en   (q_pop)
    );

    vfcao_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_word  (q_rd_word),
        .q_pop   (q_pop),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

endmodule

// ===== rtl/vfcao_front.sv =====
// Front end: takes input words and works out which faces are open.
// Drops blocks that emit nothing and hands the rest to the face queue.
// Depends on vfcao_pkg.
module vfcao_front (
    input  vfcao_pkg::item_t item,
    input  logic             push,
    input  logic             q_full,
    output logic             full,
    output logic             q_push,
    output vfcao_pkg::cls_t  q_word
);

    logic                            solid;
    logic [vfcao_pkg::NUM_FACES-1:0] mask;

    always_comb
    begin
        solid = (item.block_type > 8'd1);
        for (int f = 0; f < vfcao_pkg::NUM_FACES; f++)
        begin
            mask[f] = ~item.neighbours[vfcao_pkg::FACE_NB[f]];
        end
        if (item.pos_y == 8'(vfcao_pkg::CHUNK_HEIGHT - 1))
        begin
            mask[vfcao_pkg::FACE_TOP] = 1'b1;
        end
        if (item.pos_y == 8'd0)
        begin
            mask[vfcao_pkg::FACE_BOTTOM] = 1'b1;
        end
        full        = q_full;
        q_push      = push && !q_full && solid && (mask != '0);
        q_word.mask = mask;
        q_word.item = item;
    end

endmodule

// ===== rtl/vfcao_queue.sv =====
// Short queue of classified words between the front and back ends.
// Depends on vfcao_pkg.
module vfcao_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  vfcao_pkg::cls_t wr_data,
    output logic            full,
    output logic            valid,
    output vfcao_pkg::cls_t rd_data,
    input  logic            rd_en
);

    vfcao_pkg::cls_t                   mem [vfcao_pkg::Q_DEPTH];
    logic [vfcao_pkg::Q_PTR_W-1:0]     wptr_reg, wptr_next;
    logic [vfcao_pkg::Q_PTR_W-1:0]     rptr_reg, rptr_next;
    logic [vfcao_pkg::Q_PTR_W:0]       cnt_reg, cnt_next;
    logic                              do_rd;

    always_comb
    begin
        full      = (cnt_reg == (vfcao_pkg::Q_PTR_W + 1)'(vfcao_pkg::Q_DEPTH));
        valid     = (cnt_reg != '0);
        rd_data   = mem[rptr_reg];
        do_rd     = rd_en && valid;
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (wr_en)
        begin
            wptr_next = (wptr_reg == vfcao_pkg::Q_PTR_W'(vfcao_pkg::Q_DEPTH - 1)) ?
                        '0 : wptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rptr_next = (rptr_reg == vfcao_pkg::Q_PTR_W'(vfcao_pkg::Q_DEPTH - 1)) ?
                        '0 : rptr_reg + 1'b1;
        end
        cnt_next = cnt_reg + (vfcao_pkg::Q_PTR_W + 1)'(wr_en)
                 - (vfcao_pkg::Q_PTR_W + 1)'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wptr_reg] <= wr_data;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full)
        else $error("Face queue written while full.");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (vfcao_pkg::Q_PTR_W + 1)'(vfcao_pkg::Q_DEPTH))
        else $error("Face queue count out of range.");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !do_rd) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("Face queue count did not follow a write.");
`endif

endmodule

// ===== rtl/vfcao_back.sv =====
// Back end: walks the open faces of the head word, one per cycle when there
// is room, computes vertex occlusion and shades, buffers the result words.
// Depends on vfcao_pkg.
module vfcao_back (
    input  logic              clk,
    input  logic              rst_n,
    input  vfcao_pkg::cfg_t   cfg,
    input  logic              q_valid,
    input  vfcao_pkg::cls_t   q_word,
    output logic              q_pop,
    output vfcao_pkg::result_t result,
    output logic              empty,
    input  logic              pop
);

    typedef struct packed {
        logic [2:0] face;
        logic [7:0] tex_index;
        logic [3:0] pos_x;
        logic [7:0] pos_y;
        logic [3:0] pos_z;
        logic [8:0] light;
        logic [3:0][8:0] factor;
        logic       flip;
        logic       last;
    } stage_t;

    logic [vfcao_pkg::NUM_FACES-1:0] done_reg, done_next;
    logic [vfcao_pkg::NUM_FACES-1:0] rem, sel_bit;
    logic [2:0]                      f;
    logic                            last;
    logic                            issue;
    logic [vfcao_pkg::OUT_PTR_W+1:0] occ;
    logic [3:0][1:0]                 t;
    logic [3:0][1:0]                 a;
    logic [2:0]                      d02, d13;
    logic [1:0]                      tk;
    logic [8:0]                      loss;
    logic                            b1, b2, bc;
    stage_t                          s1_next, s1_reg;
    logic                            s1_valid_reg;
    logic [3:0][17:0]                prod;
    vfcao_pkg::result_t              wr_word;

    vfcao_pkg::result_t                mem [vfcao_pkg::OUT_DEPTH];
    logic [vfcao_pkg::OUT_PTR_W-1:0]   wptr_reg, rptr_reg;
    logic [vfcao_pkg::OUT_PTR_W:0]     cnt_reg, cnt_next;
    logic                              do_rd;

    always_comb
    begin
        rem = q_valid ? (q_word.mask & ~done_reg) : '0;
        f   = 3'd0;
        for (int i = vfcao_pkg::NUM_FACES - 1; i >= 0; i--)
        begin
            if (rem[i])
            begin
                f = 3'(i);
            end
        end
        sel_bit = vfcao_pkg::NUM_FACES'(1) << f;
        last    = ((rem & ~sel_bit) == '0);
        occ     = (vfcao_pkg::OUT_PTR_W + 2)'(cnt_reg)
                + (vfcao_pkg::OUT_PTR_W + 2)'(s1_valid_reg);
        issue   = (rem != '0) && (occ < (vfcao_pkg::OUT_PTR_W + 2)'(vfcao_pkg::OUT_DEPTH));
        q_pop   = issue && last;

        done_next = done_reg;
        if (issue)
        begin
            done_next = last ? '0 : (done_reg | sel_bit);
        end

        for (int k = 0; k < 4; k++)
        begin
            b1 = q_word.item.neighbours[vfcao_pkg::FACE_VTX[f][k][0]];
            b2 = q_word.item.neighbours[vfcao_pkg::FACE_VTX[f][k][1]];
            bc = q_word.item.neighbours[vfcao_pkg::FACE_VTX[f][k][2]];
            t[k] = (b1 && b2) ? 2'd3 : (2'(b1) + 2'(b2) + 2'(bc));
            a[k] = 2'd3 - t[k];
        end
        d02 = 3'(a[0]) + 3'(a[2]);
        d13 = 3'(a[1]) + 3'(a[3]);

        s1_next.face      = f;
        s1_next.tex_index = q_word.item.block_type - 8'd2;
        s1_next.pos_x     = q_word.item.pos_x;
        s1_next.pos_y     = q_word.item.pos_y;
        s1_next.pos_z     = q_word.item.pos_z;
        s1_next.flip      = vfcao_pkg::FACE_FLIP_LESS[f] ? (d02 < d13) : (d02 > d13);
        s1_next.last      = last;
        case (vfcao_pkg::FACE_LIGHT[f])
            vfcao_pkg::LIGHT_UP:     s1_next.light = cfg.top_light;
            vfcao_pkg::LIGHT_SIDE_X: s1_next.light = cfg.light_side_x;
            vfcao_pkg::LIGHT_SIDE_Z: s1_next.light = cfg.light_side_z;
            vfcao_pkg::LIGHT_BOTTOM: s1_next.light = cfg.light_bottom;
            default:                 s1_next.light = cfg.top_light;
        endcase
        for (int k = 0; k < 4; k++)
        begin
            tk   = t[vfcao_pkg::FACE_ORDER[f][k]];
            loss = 9'(tk) * 9'(cfg.occlusion_step);
            s1_next.factor[k] = (loss[8]) ? 9'd0 : (9'd256 - loss);
        end
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            prod[k] = 18'(s1_reg.light) * 18'(s1_reg.factor[k]) + 18'd128;
        end
        wr_word.face          = s1_reg.face;
        wr_word.tex_index     = s1_reg.tex_index;
        wr_word.out_x         = s1_reg.pos_x;
        wr_word.out_y         = s1_reg.pos_y;
        wr_word.out_z         = s1_reg.pos_z;
        wr_word.shade_a       = prod[0][16:8];
        wr_word.shade_b       = prod[1][16:8];
        wr_word.shade_c       = prod[2][16:8];
        wr_word.shade_d       = prod[3][16:8];
        wr_word.flip_diagonal = s1_reg.flip;
        wr_word.last_face     = s1_reg.last;

        empty    = (cnt_reg == '0);
        result   = mem[rptr_reg];
        do_rd    = pop && !empty;
        cnt_next = cnt_reg + (vfcao_pkg::OUT_PTR_W + 1)'(s1_valid_reg)
                 - (vfcao_pkg::OUT_PTR_W + 1)'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg     <= '0;
            s1_valid_reg <= 1'b0;
            wptr_reg     <= '0;
            rptr_reg     <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            done_reg     <= done_next;
            s1_valid_reg <= issue;
            cnt_reg      <= cnt_next;
            if (s1_valid_reg)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_reg <= s1_next;
        end
        if (s1_valid_reg)
        begin
            mem[wptr_reg] <= wr_word;
        end
    end

`ifndef ASSERT_OFF
    a_out_room: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> (cnt_reg != (vfcao_pkg::OUT_PTR_W + 1)'(vfcao_pkg::OUT_DEPTH)))
        else $error("Result buffer has no room for a finished word.");
    a_issue_head: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> q_valid)
        else $error("Face issued without a queued word.");
    a_done_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !q_valid |-> (done_reg == '0))
        else $error("Face progress left over without a queued word.");
    a_done_subset: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid |-> ((done_reg & ~q_word.mask) == '0))
        else $error("Face progress marks a face that is not open.");
`endif

endmodule
